// ----- rtl/ptl_pkg.sv -----
// shared constants, types and tables for the pose-from-two-landmarks pipeline
`timescale 1ns / 1ps

package ptl_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_OFFSET     = 3'd0,
    REG_HALF_SPACING = 3'd1,
    REG_POS_STD      = 3'd2,
    REG_HEAD_STD     = 3'd3,
    REG_X_CLIP       = 3'd4,
    REG_Y_CLIP       = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [12:0] X_OFFSET_RST     = 13'd3000;
  localparam logic [11:0] HALF_SPACING_RST = 12'd700;
  localparam logic [11:0] POS_STD_RST      = 12'd100;
  localparam logic [14:0] HEAD_STD_RST     = 15'd1024;
  localparam logic [12:0] X_CLIP_RST       = 13'd3200;
  localparam logic [12:0] Y_CLIP_RST       = 13'd2200;

  // unit latencies in cycles from input register to output register
  localparam int DIV_LAT      = 15;
  localparam int SQRT_STEPS   = 16;
  localparam int SQRT_LAT     = SQRT_STEPS + 1;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

  // whole pipeline, acceptance to output register
  localparam int PIPE_LAT = 2 + DIV_LAT + 3 + SQRT_LAT + 1 + CORDIC_LAT + 1;
  localparam int BRG_LINE = PIPE_LAT - 1;
  localparam int VAR_LINE = PIPE_LAT - 1 - (SQRT_LAT + 3);

  // largest distance to the first landmark line that can still have a solution
  localparam logic signed [16:0] DYL_MAX = 17'sd16383;

  // side data carried beside the divider
  typedef struct packed {
    logic        own;
    logic        dneg;
    logic        nf;
    logic [27:0] r0sq;
  } side_b_t;

  // side data carried beside the position root
  typedef struct packed {
    logic               own;
    logic               nf;
    logic signed [16:0] y;
    logic signed [16:0] dyl;
  } side_e_t;

  // side data carried beside the cordic
  typedef struct packed {
    logic               nf;
    logic signed [16:0] x;
    logic signed [16:0] y;
  } side_f_t;

  // arctangent of 2^-k in binary angle units
  function automatic logic [15:0] atan_tab(input int k);
    logic [15:0] v;
    case (k)
      0:       v = 16'd8192;
      1:       v = 16'd4836;
      2:       v = 16'd2555;
      3:       v = 16'd1297;
      4:       v = 16'd651;
      5:       v = 16'd326;
      6:       v = 16'd163;
      7:       v = 16'd81;
      8:       v = 16'd41;
      9:       v = 16'd20;
      10:      v = 16'd10;
      11:      v = 16'd5;
      12:      v = 16'd3;
      13:      v = 16'd1;
      14:      v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/ptl_div.sv -----
// pipelined restoring divider, 15 quotient bits, one bit per stage
`timescale 1ns / 1ps

module ptl_div (
  input  logic        clk,
  input  logic        en,
  input  logic [28:0] num,
  input  logic [13:0] den,
  output logic [14:0] quo,
  output logic        big
);

  localparam int N = ptl_pkg::DIV_LAT;

  logic [13:0] rem_q [N];
  logic [14:0] low_q [N];
  logic [14:0] quo_q [N];
  logic [13:0] den_q [N];
  logic        big_q [N];

  logic [13:0] rem_in [N];
  logic [14:0] low_in [N];
  logic [14:0] quo_in [N];
  logic [13:0] den_in [N];
  logic        big_in [N];
  logic [14:0] trial  [N];
  logic [14:0] diff   [N];
  logic        take   [N];
  logic [13:0] rem_nx [N];

  // stage inputs: upper dividend bits start the remainder
  always_comb begin
    rem_in[0] = num[28:15];
    low_in[0] = num[14:0];
    quo_in[0] = '0;
    den_in[0] = den;
    big_in[0] = (num[28:15] >= den);
    for (int i = 1; i < N; i++) begin
      rem_in[i] = rem_q[i-1];
      low_in[i] = low_q[i-1];
      quo_in[i] = quo_q[i-1];
      den_in[i] = den_q[i-1];
      big_in[i] = big_q[i-1];
    end
  end

  // one trial subtraction per stage
  always_comb begin
    for (int i = 0; i < N; i++) begin
      trial[i]  = {rem_in[i], low_in[i][14]};
      diff[i]   = trial[i] - {1'b0, den_in[i]};
      take[i]   = (trial[i] >= {1'b0, den_in[i]});
      rem_nx[i] = take[i] ? diff[i][13:0] : trial[i][13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_q[i] <= rem_nx[i];
        low_q[i] <= {low_in[i][13:0], 1'b0};
        quo_q[i] <= {quo_in[i][13:0], take[i]};
        den_q[i] <= den_in[i];
        big_q[i] <= big_in[i];
      end
    end
  end

  assign quo = quo_q[N-1];
  assign big = big_q[N-1];

endmodule

// ----- rtl/ptl_sqrt.sv -----
// pipelined square root of a 32-bit value, rounded to nearest
`timescale 1ns / 1ps

module ptl_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] radicand,
  output logic [16:0] root
);

  localparam int N = ptl_pkg::SQRT_STEPS;

  logic [17:0] rem_q [N];
  logic [15:0] acc_q [N];
  logic [31:0] low_q [N];

  logic [17:0] rem_in [N];
  logic [15:0] acc_in [N];
  logic [31:0] low_in [N];
  logic [19:0] cur    [N];
  logic [19:0] trial  [N];
  logic [19:0] diff   [N];
  logic        take   [N];

  // stage inputs
  always_comb begin
    rem_in[0] = '0;
    acc_in[0] = '0;
    low_in[0] = radicand;
    for (int i = 1; i < N; i++) begin
      rem_in[i] = rem_q[i-1];
      acc_in[i] = acc_q[i-1];
      low_in[i] = low_q[i-1];
    end
  end

  // one root digit per stage: bring down two bits, try 4r+1
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cur[i]   = {rem_in[i], low_in[i][31:30]};
      trial[i] = {2'b00, acc_in[i], 2'b01};
      diff[i]  = cur[i] - trial[i];
      take[i]  = (cur[i] >= trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_q[i] <= take[i] ? diff[i][17:0] : cur[i][17:0];
        acc_q[i] <= {acc_in[i][14:0], take[i]};
        low_q[i] <= {low_in[i][29:0], 2'b00};
      end
      // round up when the remainder exceeds the floor root
      root <= {1'b0, acc_q[N-1]} + 17'(rem_q[N-1] > {2'b00, acc_q[N-1]});
    end
  end

endmodule

// ----- rtl/ptl_cordic.sv -----
// pipelined vectoring cordic giving atan2 in 16-bit binary angle units
`timescale 1ns / 1ps

module ptl_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] dx,
  input  logic signed [15:0] dy,
  output logic        [15:0] angle
);

  localparam int N = ptl_pkg::CORDIC_STEPS;

  logic signed [33:0] cx_q   [N+1];
  logic signed [33:0] cy_q   [N+1];
  logic        [15:0] ang_q  [N+1];
  logic        [15:0] base_q [N+1];
  logic               lvl_q  [N+1];

  logic               neg;
  logic signed [16:0] ax;
  logic signed [16:0] ay;
  logic signed [33:0] sx [N];
  logic signed [33:0] sy [N];
  logic signed [33:0] cx_nx [N];
  logic signed [33:0] cy_nx [N];
  logic        [15:0] ang_nx [N];

  // turn a left-half vector by pi
  always_comb begin
    neg = dx[15];
    ax  = neg ? 17'sd0 - 17'(dx) : 17'(dx);
    ay  = neg ? 17'sd0 - 17'(dy) : 17'(dy);
  end

  // micro-rotations toward the x axis
  always_comb begin
    for (int i = 0; i < N; i++) begin
      sx[i] = cx_q[i] >>> i;
      sy[i] = cy_q[i] >>> i;
      if (!cy_q[i][33]) begin
        cx_nx[i]  = cx_q[i] + sy[i];
        cy_nx[i]  = cy_q[i] - sx[i];
        ang_nx[i] = ang_q[i] + ptl_pkg::atan_tab(i);
      end else begin
        cx_nx[i]  = cx_q[i] - sy[i];
        cy_nx[i]  = cy_q[i] + sx[i];
        ang_nx[i] = ang_q[i] - ptl_pkg::atan_tab(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_q[0]   <= 34'(ax) <<< 16;
      cy_q[0]   <= 34'(ay) <<< 16;
      ang_q[0]  <= neg ? 16'h8000 : 16'h0000;
      base_q[0] <= neg ? 16'h8000 : 16'h0000;
      lvl_q[0]  <= (dy == 16'sd0);
      for (int i = 0; i < N; i++) begin
        cx_q[i+1]  <= cx_nx[i];
        cy_q[i+1]  <= cy_nx[i];
        ang_q[i+1] <= ang_nx[i];
      end
      for (int i = 1; i <= N; i++) begin
        base_q[i] <= base_q[i-1];
        lvl_q[i]  <= lvl_q[i-1];
      end
    end
  end

  // level direction: pi for a leftward vector, else zero
  assign angle = lvl_q[N] ? base_q[N] : ang_q[N];

endmodule

// ----- rtl/pose_from_two_landmarks.sv -----
// top level: pose and variances from range and bearing to two landmarks
//
// Usage: an observation enters on the s_* stream (ranges, first bearing and
// variances in s_tdata, own-end and bad-data flags in s_tuser); one pose
// comes out on the m_* stream (found flag in m_tuser) for every transaction.
// Configuration is written through cfg_we/cfg_index/cfg_data while no
// transaction is in flight; indexes above the last register are ignored.
// The latency is set by the chain of divider, position root and cordic
// pipelines plus the glue stages. Throughput is one transaction per cycle
// while the output is not stalled.
// The whole pipeline advances on one enable: when m_tvalid is high and
// m_tready low, every stage and s_tready hold, so nothing is lost or
// repeated; bubbles behind the held result are kept as they are.
// Reset (rst, synchronous) empties the pipeline and reloads the register
// defaults; the block accepts transactions in the next cycle.
`timescale 1ns / 1ps

module pose_from_two_landmarks (
  input  logic         clk,
  input  logic         rst,
  // config write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_range, first_bearing, second_range, first_range_variance,
  // second_range_variance, first_bearing_variance, zero pad
  input  logic [143:0] s_tdata,
  // own_end, data_bad
  input  logic [1:0]   s_tuser,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pose_heading, position_variance, heading_variance, zero pad
  output logic [111:0] m_tdata,
  // found
  output logic [0:0]   m_tuser
);

  localparam int LAT = ptl_pkg::PIPE_LAT;

  // configuration registers
  logic [12:0] x_offset;
  logic [11:0] half_spacing;
  logic [11:0] pos_std;
  logic [14:0] head_std;
  logic [12:0] x_clip;
  logic [12:0] y_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset     <= ptl_pkg::X_OFFSET_RST;
      half_spacing <= ptl_pkg::HALF_SPACING_RST;
      pos_std      <= ptl_pkg::POS_STD_RST;
      head_std     <= ptl_pkg::HEAD_STD_RST;
      x_clip       <= ptl_pkg::X_CLIP_RST;
      y_clip       <= ptl_pkg::Y_CLIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ptl_pkg::REG_X_OFFSET:     x_offset     <= cfg_data[12:0];
        ptl_pkg::REG_HALF_SPACING: half_spacing <= cfg_data[11:0];
        ptl_pkg::REG_POS_STD:      pos_std      <= cfg_data[11:0];
        ptl_pkg::REG_HEAD_STD:     head_std     <= cfg_data;
        ptl_pkg::REG_X_CLIP:       x_clip       <= cfg_data[12:0];
        ptl_pkg::REG_Y_CLIP:       y_clip       <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  logic en;
  logic vld [LAT];

  assign m_tvalid = vld[LAT-1];
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // input fields
  logic [13:0] in_r0;
  logic [15:0] in_brg;
  logic [13:0] in_r1;
  logic [31:0] in_v0;
  logic [31:0] in_v1;
  logic [31:0] in_vb;
  logic [32:0] vsum;

  assign in_r0  = s_tdata[13:0];
  assign in_brg = s_tdata[29:14];
  assign in_r1  = s_tdata[43:30];
  assign in_v0  = s_tdata[75:44];
  assign in_v1  = s_tdata[107:76];
  assign in_vb  = s_tdata[139:108];
  assign vsum   = {1'b0, in_v0} + {1'b0, in_v1};

  // stage a: squares of the ranges, mean range variance
  logic [27:0] a_r0sq;
  logic [27:0] a_r1sq;
  logic        a_own;
  logic        a_bad;
  logic [31:0] a_vmean;
  logic [31:0] a_vb;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r0sq  <= in_r0 * in_r0;
      a_r1sq  <= in_r1 * in_r1;
      a_own   <= s_tuser[0];
      a_bad   <= s_tuser[1];
      a_vmean <= vsum[32:1];
      a_vb    <= in_vb;
    end
  end

  // stage b: difference of squares and divider operands
  logic [28:0] d_sq;
  logic [28:0] d_neg;
  logic [27:0] d_mag;
  logic [28:0] b_num;
  logic [13:0] b_den;
  ptl_pkg::side_b_t b_side;

  assign d_sq  = {1'b0, a_r0sq} - {1'b0, a_r1sq};
  assign d_neg = 29'd0 - d_sq;
  assign d_mag = d_sq[28] ? d_neg[27:0] : d_sq[27:0];

  always_ff @(posedge clk) begin
    if (en) begin
      b_num       <= {1'b0, d_mag} + {16'd0, half_spacing, 1'b0};
      b_den       <= {half_spacing, 2'b00};
      b_side.own  <= a_own;
      b_side.dneg <= d_sq[28];
      b_side.nf   <= a_bad || (half_spacing == 12'd0);
      b_side.r0sq <= a_r0sq;
    end
  end

  // divider and its side line
  logic [14:0] quo;
  logic        big;
  ptl_pkg::side_b_t line_b [ptl_pkg::DIV_LAT];
  ptl_pkg::side_b_t sb;

  ptl_div u_div (
    .clk (clk),
    .en  (en),
    .num (b_num),
    .den (b_den),
    .quo (quo),
    .big (big)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      line_b[0] <= b_side;
      for (int i = 1; i < ptl_pkg::DIV_LAT; i++) line_b[i] <= line_b[i-1];
    end
  end

  assign sb = line_b[ptl_pkg::DIV_LAT-1];

  // stage c: signed y and offset to the first landmark line
  logic signed [16:0] y_v;
  logic signed [16:0] hs_v;
  logic signed [16:0] dyl_v;
  logic signed [16:0] c_y;
  logic signed [16:0] c_dyl;
  logic               c_own;
  logic               c_nf;
  logic [27:0]        c_r0sq;

  always_comb begin
    y_v   = (sb.own ^ sb.dneg) ? 17'({2'b00, quo}) : 17'sd0 - 17'({2'b00, quo});
    hs_v  = sb.own ? 17'({5'd0, half_spacing}) : 17'sd0 - 17'({5'd0, half_spacing});
    dyl_v = y_v + hs_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_y    <= y_v;
      c_dyl  <= dyl_v;
      c_own  <= sb.own;
      c_nf   <= sb.nf || big || (dyl_v > ptl_pkg::DYL_MAX) || (dyl_v < -ptl_pkg::DYL_MAX);
      c_r0sq <= sb.r0sq;
    end
  end

  // stage d: square of the landmark line offset
  logic [16:0]        dyl_abs;
  logic [29:0]        d_dsq;
  logic signed [16:0] d_y;
  logic signed [16:0] d_dyl;
  logic               d_own;
  logic               d_nf;
  logic [27:0]        d_r0sq;

  assign dyl_abs = c_dyl[16] ? 17'd0 - 17'(c_dyl) : 17'(c_dyl);

  always_ff @(posedge clk) begin
    if (en) begin
      d_dsq  <= dyl_abs[14:0] * dyl_abs[14:0];
      d_y    <= c_y;
      d_dyl  <= c_dyl;
      d_own  <= c_own;
      d_nf   <= c_nf;
      d_r0sq <= c_r0sq;
    end
  end

  // stage e: remaining squared range along x
  logic [30:0] xo;
  logic [31:0] e_xo;
  ptl_pkg::side_e_t e_side;

  assign xo = {3'd0, d_r0sq} - {1'b0, d_dsq};

  always_ff @(posedge clk) begin
    if (en) begin
      e_xo       <= {1'b0, xo};
      e_side.own <= d_own;
      e_side.nf  <= d_nf || xo[30];
      e_side.y   <= d_y;
      e_side.dyl <= d_dyl;
    end
  end

  // position root and its side line
  logic [16:0] q_root;
  ptl_pkg::side_e_t line_e [ptl_pkg::SQRT_LAT];
  ptl_pkg::side_e_t se;

  ptl_sqrt u_sqrt_pos (
    .clk      (clk),
    .en       (en),
    .radicand (e_xo),
    .root     (q_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      line_e[0] <= e_side;
      for (int i = 1; i < ptl_pkg::SQRT_LAT; i++) line_e[i] <= line_e[i-1];
    end
  end

  assign se = line_e[ptl_pkg::SQRT_LAT-1];

  // stage f: x position and cordic operands
  logic signed [16:0] x_v;
  logic signed [15:0] f_dx;
  logic signed [15:0] f_dy;
  ptl_pkg::side_f_t f_side;

  assign x_v = se.own ? 17'(q_root) - 17'({4'd0, x_offset})
                      : 17'({4'd0, x_offset}) - 17'(q_root);

  always_ff @(posedge clk) begin
    if (en) begin
      f_dx      <= se.own ? 16'd0 - q_root[15:0] : q_root[15:0];
      f_dy      <= 16'd0 - se.dyl[15:0];
      f_side.nf <= se.nf;
      f_side.x  <= x_v;
      f_side.y  <= se.y;
    end
  end

  // heading cordic and its side line
  logic [15:0] ang;
  ptl_pkg::side_f_t line_f [ptl_pkg::CORDIC_LAT];
  ptl_pkg::side_f_t sf;

  ptl_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .dx    (f_dx),
    .dy    (f_dy),
    .angle (ang)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      line_f[0] <= f_side;
      for (int i = 1; i < ptl_pkg::CORDIC_LAT; i++) line_f[i] <= line_f[i-1];
    end
  end

  assign sf = line_f[ptl_pkg::CORDIC_LAT-1];

  // bearing delay to the output stage
  logic [15:0] brg_line [ptl_pkg::BRG_LINE];

  always_ff @(posedge clk) begin
    if (en) begin
      brg_line[0] <= in_brg;
      for (int i = 1; i < ptl_pkg::BRG_LINE; i++) brg_line[i] <= brg_line[i-1];
    end
  end

  // variance path: roots, offsets, saturating squares
  logic [16:0] pv_root;
  logic [16:0] hv_root;
  logic [17:0] pv_sd;
  logic [17:0] hv_sd;
  logic [35:0] pv_sq;
  logic [35:0] hv_sq;
  logic [31:0] pv_sat;
  logic [31:0] hv_sat;
  logic [31:0] pv_line [ptl_pkg::VAR_LINE];
  logic [31:0] hv_line [ptl_pkg::VAR_LINE];

  ptl_sqrt u_sqrt_pvar (
    .clk      (clk),
    .en       (en),
    .radicand (a_vmean),
    .root     (pv_root)
  );

  ptl_sqrt u_sqrt_hvar (
    .clk      (clk),
    .en       (en),
    .radicand (a_vb),
    .root     (hv_root)
  );

  assign pv_sq = pv_sd * pv_sd;
  assign hv_sq = hv_sd * hv_sd;

  always_ff @(posedge clk) begin
    if (en) begin
      pv_sd  <= {1'b0, pv_root} + {6'd0, pos_std};
      hv_sd  <= {1'b0, hv_root} + {3'd0, head_std};
      pv_sat <= (pv_sq[35:32] != 4'd0) ? 32'hFFFF_FFFF : pv_sq[31:0];
      hv_sat <= (hv_sq[35:32] != 4'd0) ? 32'hFFFF_FFFF : hv_sq[31:0];
      pv_line[0] <= pv_sat;
      hv_line[0] <= hv_sat;
      for (int i = 1; i < ptl_pkg::VAR_LINE; i++) begin
        pv_line[i] <= pv_line[i-1];
        hv_line[i] <= hv_line[i-1];
      end
    end
  end

  // output stage: clip, heading, not-found zeroing
  logic signed [17:0] xs;
  logic signed [17:0] ys;
  logic signed [17:0] xl;
  logic signed [17:0] yl;
  logic signed [17:0] xc;
  logic signed [17:0] yc;
  logic [15:0]        head;

  always_comb begin
    xs = 18'(sf.x);
    ys = 18'(sf.y);
    xl = 18'({5'd0, x_clip});
    yl = 18'({5'd0, y_clip});
    if (xs > xl)       xc = xl;
    else if (xs < -xl) xc = -xl;
    else               xc = xs;
    if (ys > yl)       yc = yl;
    else if (ys < -yl) yc = -yl;
    else               yc = ys;
    head = ang - brg_line[ptl_pkg::BRG_LINE-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sf.nf) begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= {4'd0, hv_line[ptl_pkg::VAR_LINE-1], pv_line[ptl_pkg::VAR_LINE-1],
                    head, yc[13:0], xc[13:0]};
        m_tuser <= 1'b1;
      end
    end
  end

endmodule

// ----- bench/pose_checker.sv -----
// checker: watches both streams, predicts each pose and compares it
`timescale 1ns / 1ps

module pose_checker
  import ptl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic [0:0]   m_tuser,
  output int           fail_count,
  output int           pending_poses
);

  typedef struct packed {
    logic               found;
    logic signed [13:0] pos_x;
    logic signed [13:0] pos_y;
    logic signed [15:0] heading;
    logic [31:0]        pos_var;
    logic [31:0]        head_var;
  } pose_t;

  pose_t pose_queue[$];

  logic [12:0] x_off;
  logic [11:0] half_sp;
  logic [11:0] pos_std;
  logic [14:0] head_std;
  logic [12:0] x_clip;
  logic [12:0] y_clip;

  // rounded square root, bit by bit
  function automatic longint unsigned isqrt_round(input longint unsigned n);
    longint unsigned res, rem, b;
    res = 0;
    rem = n;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    if (rem > res) res++;
    return res;
  endfunction

  // vectoring cordic, angle in binary units
  function automatic int angle_of(input longint dy, input longint dx);
    int ang;
    longint cx, cy, sx, sy;
    int tab[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                    41, 20, 10, 5, 3, 1, 1, 0};
    if (dy == 0) return (dx < 0) ? 32768 : 0;
    ang = 0;
    cx = dx * 65536;
    cy = dy * 65536;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      ang = 32768;
    end
    for (int i = 0; i < 16; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx += sy;
        cy -= sx;
        ang += tab[i];
      end else begin
        cx -= sy;
        cy += sx;
        ang -= tab[i];
      end
    end
    return ang;
  endfunction

  function automatic logic [31:0] sat_sq(input longint unsigned v);
    longint unsigned sq;
    sq = v * v;
    return (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
  endfunction

  function automatic longint clamp(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // pose predicted from one observation
  function automatic pose_t predict_pose(input logic [143:0] d, input logic [1:0] u);
    pose_t p;
    longint s, r0, r1, h, dd, mag, y, dyl, xo, q, x, brg;
    int ang;
    logic [31:0] head;
    p = '0;
    s = u[0] ? 1 : -1;
    r0 = d[13:0];
    brg = $signed(d[29:14]);
    r1 = d[43:30];
    h = half_sp;
    if (u[1] || h == 0) return p;
    dd = r0 * r0 - r1 * r1;
    mag = (dd < 0) ? -dd : dd;
    mag = (mag + 2 * h) / (4 * h);
    y = s * ((dd < 0) ? -mag : mag);
    dyl = y + s * h;
    xo = r0 * r0 - dyl * dyl;
    if (xo < 0) return p;
    q = isqrt_round(xo);
    x = s * (q - longint'(x_off));
    ang = angle_of(-s * h - y, -s * q);
    head = ang - int'(brg);
    p.found = 1'b1;
    p.pos_x = 14'(clamp(x, x_clip));
    p.pos_y = 14'(clamp(y, y_clip));
    p.heading = head[15:0];
    p.pos_var = sat_sq(isqrt_round((64'(d[75:44]) + 64'(d[107:76])) >> 1) + pos_std);
    p.head_var = sat_sq(isqrt_round(d[139:108]) + head_std);
    return p;
  endfunction

  assign pending_poses = pose_queue.size();

  // register shadow, predictions and comparison
  always @(posedge clk) begin
    pose_t want, got;
    if (rst) begin
      x_off <= X_OFFSET_RST;
      half_sp <= HALF_SPACING_RST;
      pos_std <= POS_STD_RST;
      head_std <= HEAD_STD_RST;
      x_clip <= X_CLIP_RST;
      y_clip <= Y_CLIP_RST;
      fail_count <= 0;
      pose_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_X_OFFSET:     x_off <= cfg_data[12:0];
          REG_HALF_SPACING: half_sp <= cfg_data[11:0];
          REG_POS_STD:      pos_std <= cfg_data[11:0];
          REG_HEAD_STD:     head_std <= cfg_data[14:0];
          REG_X_CLIP:       x_clip <= cfg_data[12:0];
          REG_Y_CLIP:       y_clip <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pose_queue.push_back(predict_pose(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        got.found = m_tuser[0];
        got.pos_x = m_tdata[13:0];
        got.pos_y = m_tdata[27:14];
        got.heading = m_tdata[43:28];
        got.pos_var = m_tdata[75:44];
        got.head_var = m_tdata[107:76];
        if (pose_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected pose transaction %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = pose_queue.pop_front();
          if (want !== got) begin
            if (fail_count < 10) $display("pose mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/pose_from_two_landmarks_tb.sv -----
// testbench top: observation stimulus, config phases, stalls and verdict
`timescale 1ns / 1ps

module pose_from_two_landmarks_tb;
  import ptl_pkg::*;

  localparam int WATCHDOG = 20000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [14:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;
  logic [0:0]   m_tuser;
  int           fail_count;
  int           pending_poses;
  logic         sink_hold;
  logic         calm;
  int           idle_cycles;

  pose_from_two_landmarks DUT (.*);

  pose_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    m_tready = 0;
    sink_hold = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        m_tready = 0;
        repeat (300) @(negedge clk);
        sink_hold = 0;
      end
      m_tready = calm ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [14:0] val);
    @(negedge clk);
    s_tvalid = 0;
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // let every pose drain and the pipeline empty
  task automatic drain;
    @(negedge clk);
    s_tvalid = 0;
    while (pending_poses != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  // offer one observation, holding it until accepted
  task automatic send_obs(input logic own, input logic bad, input logic [13:0] r0,
                          input logic [15:0] brg, input logic [13:0] r1,
                          input logic [31:0] v0, input logic [31:0] v1,
                          input logic [31:0] vb);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = {bad, own};
    s_tdata = {4'd0, vb, v1, v0, r1, brg, r0};
    do @(posedge clk); while (!s_tready);
  endtask

  // ranges built around a position on the field, so most give a solution
  task automatic send_random;
    int px, py, s, dx0, dy0, dy1, j, r0, r1;
    logic [31:0] v0, v1, vb;
    s = $urandom_range(1) ? 1 : -1;
    px = $urandom_range(6000) - 3000;
    py = $urandom_range(4000) - 2000;
    dx0 = px + s * 3000;
    dy0 = py + s * 700;
    dy1 = py - s * 700;
    r0 = $rtoi($sqrt(real'(dx0 * dx0 + dy0 * dy0)));
    r1 = $rtoi($sqrt(real'(dx0 * dx0 + dy1 * dy1)));
    j = $urandom_range(99);
    if (j < 15) r0 = $urandom_range(16383);
    if (j < 25) r1 = $urandom_range(16383);
    if (r0 > 16383) r0 = 16383;
    if (r1 > 16383) r1 = 16383;
    v0 = $urandom;
    v1 = $urandom;
    vb = $urandom;
    if ($urandom_range(3) != 0) begin
      v0 = v0 >> $urandom_range(31);
      v1 = v1 >> $urandom_range(31);
      vb = vb >> $urandom_range(31);
    end
    send_obs(s > 0, $urandom_range(99) < 5, 14'(r0), 16'($urandom), 14'(r1), v0, v1, vb);
  endtask

  task automatic directed_set;
    send_obs(1, 0, 3622, 16'h0000, 3622, 0, 0, 0);
    send_obs(0, 0, 3622, 16'h8000, 2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_obs(1, 1, 3000, 16'h7FFF, 2500, 100, 200, 300);
    send_obs(1, 0, 100, 16'h1234, 9000, 5, 5, 5);
    send_obs(0, 0, 16383, 16'hFFFF, 16383, 1, 2, 3);
    send_obs(1, 0, 0, 16'h0001, 0, 0, 1, 0);
    send_obs(1, 0, 16383, 16'h4000, 0, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
    send_obs(0, 0, 0, 16'hC000, 16383, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0FFF_FFFF);
    send_obs(1, 0, 700, 16'h0100, 700, 9, 9, 9);
    send_obs(0, 0, 5000, 16'hA5A5, 4000, 44, 55, 66);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_X_OFFSET;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    calm = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed items at reset settings, no idling
    calm = 1;
    directed_set();
    drain();
    calm = 0;

    // extreme settings, including zero spacing and zero clips
    write_reg(REG_HALF_SPACING, 0);
    write_reg(REG_X_CLIP, 0);
    write_reg(REG_Y_CLIP, 0);
    write_reg(REG_X_OFFSET, 8191);
    write_reg(REG_POS_STD, 4095);
    write_reg(REG_HEAD_STD, 32767);
    write_reg(cfg_reg_t'(3'd7), 15'h7FFF);
    directed_set();
    drain();
    write_reg(REG_HALF_SPACING, 4095);
    directed_set();
    drain();

    write_reg(REG_HALF_SPACING, 1);
    write_reg(REG_X_CLIP, 8191);
    write_reg(REG_Y_CLIP, 8191);
    write_reg(REG_X_OFFSET, 0);
    write_reg(REG_POS_STD, 0);
    write_reg(REG_HEAD_STD, 0);
    for (int i = 0; i < 60; i++) send_random();
    drain();

    // reset settings, long receiver hold-off while the sender keeps offering
    write_reg(REG_HALF_SPACING, HALF_SPACING_RST);
    write_reg(REG_X_OFFSET, X_OFFSET_RST);
    write_reg(REG_POS_STD, POS_STD_RST);
    write_reg(REG_HEAD_STD, HEAD_STD_RST);
    write_reg(REG_X_CLIP, X_CLIP_RST);
    write_reg(REG_Y_CLIP, Y_CLIP_RST);
    sink_hold = 1;
    calm = 1;
    for (int i = 0; i < 120; i++) send_random();
    calm = 0;
    for (int i = 0; i < 300; i++) send_random();
    // sender pause until every pose is back
    drain();
    write_reg(REG_HALF_SPACING, 1200);
    write_reg(REG_Y_CLIP, 1500);
    write_reg(REG_X_CLIP, 2800);
    for (int i = 0; i < 300; i++) send_random();

    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ptl_pkg.sv
rtl/ptl_div.sv
rtl/ptl_sqrt.sv
rtl/ptl_cordic.sv
rtl/pose_from_two_landmarks.sv
bench/pose_checker.sv
bench/pose_from_two_landmarks_tb.sv
